FILE: design/lrp_pkg.sv
package lrp_pkg;

	// defaults for the top-level parameters
	localparam int FRAMES_DEF    = 4;
	localparam int PAGE_BITS_DEF = 20;

	// fixed field widths
	localparam int PAGE_W  = 20;
	localparam int COUNT_W = 16;
	localparam int FRAME_W = 2;
	localparam int OUTC_W  = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// command codes
	localparam logic CMD_ACCESS = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// outcome codes
	localparam logic [OUTC_W-1:0] OUT_HIT     = 2'd0;
	localparam logic [OUTC_W-1:0] OUT_FILL    = 2'd1;
	localparam logic [OUTC_W-1:0] OUT_REPLACE = 2'd2;
	localparam logic [OUTC_W-1:0] OUT_CLEARED = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic load_in;  // capture the input transaction
		logic exec;     // apply the captured access and load the output register
	} ctl_cmd_t;

endpackage

FILE: design/lrp_ctrl.sv
module lrp_ctrl
	import lrp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output ctl_cmd_t ctl
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;

	assign s_tready    = (state_q == ST_IDLE);
	assign ctl.load_in = s_tvalid && s_tready;
	// output register free or draining this cycle
	assign ctl.exec    = (state_q == ST_EXEC) && (!m_tvalid_q || m_tready);
	assign m_tvalid    = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ctl.exec)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.load_in)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (ctl.exec)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_exec_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |=> m_tvalid)
		else $error("result not presented after execute");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !ctl.exec)
		else $error("pending result overwritten");

endmodule

FILE: design/lrp_datapath.sv
module lrp_datapath
	import lrp_pkg::*;
#(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_cmd_t            ctl,
	input  logic                in_cmd,
	input  logic [PAGE_W-1:0]   in_page,
	output logic [OUTC_W-1:0]   outcome,
	output logic [FRAME_W-1:0]  frame,
	output logic [PAGE_W-1:0]   evicted_page,
	output logic [COUNT_W-1:0]  fault_total
);

	localparam int RW = $clog2(FRAMES);                         // rank / index width
	localparam int SW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W; // stored page bits
	localparam logic [RW-1:0] RANK_OLDEST = RW'(FRAMES - 1);
	localparam logic [RW:0]   LIM_ALL     = (RW + 1)'(FRAMES);
	localparam logic [RW:0]   LIM_OLDEST  = (RW + 1)'(FRAMES - 1);

	// captured input
	logic          cmd_q;
	logic [SW-1:0] page_q;

	// frame table
	logic [FRAMES-1:0] frame_valid_q;
	logic [SW-1:0]     frame_page_q [FRAMES];
	logic [RW-1:0]     rank_q       [FRAMES];
	logic [COUNT_W-1:0] fault_q;

	// output register
	logic [OUTC_W-1:0]  outcome_q;
	logic [FRAME_W-1:0] frame_q;
	logic [PAGE_W-1:0]  evict_q;
	logic [COUNT_W-1:0] total_q;

	logic          hit_found, empty_found;
	logic [RW-1:0] hit_idx, free_idx, victim_idx, sel_idx;
	logic [RW:0]   limit;
	logic [RW+1:0] sel_wide;
	logic [COUNT_W-1:0] fault_nxt;

	// lowest matching and lowest empty frame, frame holding the oldest rank
	always_comb begin
		hit_found   = 1'b0;
		empty_found = 1'b0;
		hit_idx     = '0;
		free_idx    = '0;
		victim_idx  = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if (!hit_found && frame_valid_q[i] && frame_page_q[i] == page_q) begin
				hit_found = 1'b1;
				hit_idx   = RW'(i);
			end
			if (!empty_found && !frame_valid_q[i]) begin
				empty_found = 1'b1;
				free_idx    = RW'(i);
			end
		end
		// table full: ranks are a permutation, so exactly one frame is oldest
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (rank_q[i] == RANK_OLDEST)
				victim_idx = RW'(i);
		end
	end

	// frame touched and the aging limit for the other frames
	always_comb begin
		if (hit_found) begin
			sel_idx = hit_idx;
			limit   = {1'b0, rank_q[hit_idx]};
		end else if (empty_found) begin
			sel_idx = free_idx;
			limit   = LIM_ALL;
		end else begin
			sel_idx = victim_idx;
			limit   = LIM_OLDEST;
		end
		if (hit_found || fault_q == COUNT_MAX)
			fault_nxt = fault_q;
		else
			fault_nxt = fault_q + 1'b1;
	end

	assign sel_wide = {2'b00, sel_idx};

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q  <= in_cmd;
			page_q <= in_page[SW-1:0];
		end
		if (ctl.exec) begin
			if (cmd_q == CMD_CLEAR) begin
				outcome_q <= OUT_CLEARED;
				frame_q   <= '0;
				evict_q   <= '0;
				total_q   <= '0;
			end else begin
				frame_q <= sel_wide[FRAME_W-1:0];
				total_q <= fault_nxt;
				if (hit_found) begin
					outcome_q <= OUT_HIT;
					evict_q   <= '0;
				end else if (empty_found) begin
					outcome_q <= OUT_FILL;
					evict_q   <= '0;
				end else begin
					outcome_q <= OUT_REPLACE;
					evict_q   <= PAGE_W'(frame_page_q[victim_idx]);
				end
				if (!hit_found)
					frame_page_q[sel_idx] <= page_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= '0;
			fault_q       <= '0;
			for (int i = 0; i < FRAMES; i++)
				rank_q[i] <= '0;
		end else if (ctl.exec) begin
			if (cmd_q == CMD_CLEAR) begin
				frame_valid_q <= '0;
				fault_q       <= '0;
				for (int i = 0; i < FRAMES; i++)
					rank_q[i] <= '0;
			end else begin
				fault_q                <= fault_nxt;
				frame_valid_q[sel_idx] <= 1'b1;
				for (int i = 0; i < FRAMES; i++) begin
					if (RW'(i) == sel_idx)
						rank_q[i] <= '0;
					else if (frame_valid_q[i] && {1'b0, rank_q[i]} < limit)
						rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
		end
	end

	assign outcome      = outcome_q;
	assign frame        = frame_q;
	assign evicted_page = evict_q;
	assign fault_total  = total_q;

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.exec && cmd_q == CMD_CLEAR) |=> (frame_valid_q == '0 && fault_q == '0))
		else $error("clear left frames or count");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.exec && cmd_q == CMD_ACCESS) |=> (fault_q >= $past(fault_q)))
		else $error("fault count went down");

	a_valid_grows: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.exec && cmd_q == CMD_CLEAR) |=>
		((frame_valid_q & $past(frame_valid_q)) == $past(frame_valid_q)))
		else $error("frame emptied without clear");

endmodule

FILE: design/lru_page_replacement_core.sv
// LRU page replacement core. Keeps FRAMES physical frames, each empty or holding a
// page number, and answers one result transaction per input transaction. An access
// that matches a valid frame is a hit and becomes the most recent; a miss fills the
// lowest-numbered empty frame, or, with every frame in use, evicts the least recently
// used one and reports its old page. A 16-bit fault count saturates at 65535; a clear
// command empties all frames and the count. Each transaction first registers the
// input; then, once the output register is free, all frames are compared in parallel
// and the frame table, recency ranks and output register update together. The output
// register lets the next input transaction enter while a result waits on m_tready.
// Reset takes effect at once; there is no clearing pass.
module lru_page_replacement_core
	import lrp_pkg::*;
#(
	parameter int FRAMES    = FRAMES_DEF,   // 2 .. 4
	parameter int PAGE_BITS = PAGE_BITS_DEF // 1 .. 20, low bits of page compared
) (
	input  logic        clk,
	input  logic        arst_n,
	// input transactions
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [19:0] page, [23:20] zero
	input  logic [0:0]  s_tuser,  // [0] cmd
	// result transactions
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [1:0] frame, [21:2] evicted_page, [37:22] fault_total
	output logic [1:0]  m_tuser   // [1:0] outcome
);

	ctl_cmd_t           ctl;
	logic [FRAME_W-1:0] frame;
	logic [PAGE_W-1:0]  evicted_page;
	logic [COUNT_W-1:0] fault_total;

	// sequencing: accept, execute, hold result
	lrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.ctl      (ctl)
	);

	// frame table, recency ranks, fault count, output register
	lrp_datapath #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.in_cmd       (s_tuser[0]),
		.in_page      (s_tdata[PAGE_W-1:0]),
		.outcome      (m_tuser),
		.frame        (frame),
		.evicted_page (evicted_page),
		.fault_total  (fault_total)
	);

	assign m_tdata = {2'b00, fault_total, evicted_page, frame};

endmodule

FILE: dv/lru_page_replacement_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the LRU page replacement core.
// Access transactions are queued by the stimulus block and driven at the falling
// edge. At each rising edge every accepted access runs through a local LRU frame
// table, and the predicted lookup result is queued. Every result transaction is
// compared field by field against the oldest prediction.
module lru_page_replacement_core_tb;
	import lrp_pkg::*;

	localparam int NFRAMES          = FRAMES_DEF;
	localparam int RANDOM_PER_PHASE = 400;
	localparam int CYCLE_LIMIT      = 900000;
	localparam int DRAIN_CYCLES     = 20;
	localparam int MAX_PRINTS       = 50;
	localparam logic [PAGE_W-1:0] PAGE_MASK = PAGE_W'((64'd1 << PAGE_BITS_DEF) - 64'd1);

	typedef struct packed {
		logic              cmd;
		logic [PAGE_W-1:0] page;
	} access_t;

	typedef struct packed {
		logic [OUTC_W-1:0]  outcome;
		logic [FRAME_W-1:0] frame;
		logic [PAGE_W-1:0]  evicted;
		logic [COUNT_W-1:0] total;
	} lookup_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;  // [19:0] page, [23:20] zero
	logic [0:0]  s_tuser  = '0;  // [0] cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // [1:0] frame, [21:2] evicted_page, [37:22] fault_total
	logic [1:0]  m_tuser;        // [1:0] outcome

	lru_page_replacement_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// pending accesses and predicted lookup results
	access_t access_q[$];
	lookup_t lookup_q[$];
	access_t next_access;
	lookup_t want;
	int      n_driven = 0;  // accesses put on the bus; all taken once n_taken catches up

	// idle percentages of the current phase
	int send_idle = 0;
	int recv_idle = 0;

	// shadow frame table
	bit                 frm_used [NFRAMES];
	logic [PAGE_W-1:0]  frm_page [NFRAMES];
	int unsigned        frm_age  [NFRAMES];   // 0 = most recent
	logic [COUNT_W-1:0] faults;

	// page pool for working-set style traffic
	logic [PAGE_W-1:0] pool [8];
	int                pool_n = 4;

	int  cycles = 0;
	int  errors = 0;
	int  n_taken = 0, n_hit = 0, n_fill = 0, n_repl = 0, n_clear = 0;
	bit  saturated = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void frames_clear();
		for (int i = 0; i < NFRAMES; i++) begin
			frm_used[i] = 1'b0;
			frm_page[i] = '0;
			frm_age[i]  = 0;
		end
		faults = '0;
	endfunction

	// frame f becomes most recent; valid frames younger than limit age by one
	function automatic void promote(int f, int unsigned limit);
		for (int i = 0; i < NFRAMES; i++) begin
			if (i != f && frm_used[i] && frm_age[i] < limit)
				frm_age[i]++;
		end
		frm_age[f] = 0;
	endfunction

	function automatic lookup_t lru_lookup(access_t a);
		lookup_t           r;
		int                hit, empty, victim;
		int unsigned       oldest;
		logic [PAGE_W-1:0] pg;
		r      = '0;
		hit    = -1;
		empty  = -1;
		victim = -1;
		oldest = 0;
		pg     = a.page & PAGE_MASK;
		if (a.cmd == CMD_CLEAR) begin
			frames_clear();
			r.outcome = OUT_CLEARED;
			n_clear++;
			return r;
		end
		for (int i = 0; i < NFRAMES; i++) begin
			// an empty frame never matches, stale page or not
			if (frm_used[i] && frm_page[i] == pg && hit < 0)
				hit = i;
			if (!frm_used[i] && empty < 0)
				empty = i;
		end
		if (hit >= 0) begin
			promote(hit, frm_age[hit]);
			r.outcome = OUT_HIT;
			r.frame   = FRAME_W'(hit);
			n_hit++;
		end else begin
			if (faults != COUNT_MAX)
				faults++;
			if (empty >= 0) begin
				frm_used[empty] = 1'b1;
				frm_page[empty] = pg;
				promote(empty, 255);
				r.outcome = OUT_FILL;
				r.frame   = FRAME_W'(empty);
				n_fill++;
			end else begin
				for (int i = 0; i < NFRAMES; i++) begin
					if (victim < 0 || frm_age[i] > oldest) begin
						oldest = frm_age[i];
						victim = i;
					end
				end
				r.evicted        = frm_page[victim];
				frm_page[victim] = pg;
				promote(victim, oldest);
				r.outcome = OUT_REPLACE;
				r.frame   = FRAME_W'(victim);
				n_repl++;
			end
		end
		if (faults == COUNT_MAX)
			saturated = 1'b1;
		r.total = faults;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
		if (errors < MAX_PRINTS)
			$display("cycle %0d: %s got %0h exp %0h", cycles, what, got, exp_val);
		errors++;
	endtask

	task automatic check_field(string what, logic [63:0] got, logic [63:0] exp_val);
		if (got !== exp_val)
			report_mismatch(what, got, exp_val);
	endtask

	task automatic push_access(logic cmd, logic [PAGE_W-1:0] page);
		access_t a;
		a.cmd  = cmd;
		a.page = page;
		access_q.push_back(a);
	endtask

	// mostly working-set accesses; some near misses, fresh pages and clears
	function automatic access_t rand_access();
		access_t a;
		int      r;
		r      = $urandom_range(99);
		a.cmd  = CMD_ACCESS;
		a.page = pool[$urandom_range(pool_n - 1)];
		if (r < 3) begin
			a.cmd  = CMD_CLEAR;
			a.page = PAGE_W'($urandom);
		end else if (r < 13) begin
			a.page = a.page ^ (PAGE_W'(1) << $urandom_range(PAGE_W - 1));
		end else if (r < 25) begin
			a.page = PAGE_W'($urandom);
			pool[$urandom_range(7)] = a.page;
		end
		return a;
	endfunction

	task automatic add_random(int n);
		for (int i = 0; i < n; i++) begin
			// working-set size drifts around the frame count
			if (i % 50 == 0)
				pool_n = $urandom_range(3, 8);
			access_q.push_back(rand_access());
		end
	endtask

	task automatic wait_drained();
		while (access_q.size() != 0 || s_tvalid || lookup_q.size() != 0)
			@(posedge clk);
	endtask

	// sender: next access at the falling edge once the current one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (n_taken == n_driven) begin
			if (access_q.size() != 0 && $urandom_range(99) >= send_idle) begin
				next_access = access_q.pop_front();
				n_driven++;
				s_tvalid <= 1'b1;
				s_tdata  <= {{(24 - PAGE_W){1'b0}}, next_access.page};
				s_tuser  <= next_access.cmd;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// rising edge: score result transactions, then predict the accepted access
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (lookup_q.size() == 0) begin
					report_mismatch("result with nothing pending", m_tdata, 0);
				end else begin
					want = lookup_q.pop_front();
					check_field("outcome", m_tuser, want.outcome);
					check_field("frame", m_tdata[1:0], want.frame);
					check_field("evicted_page", m_tdata[21:2], want.evicted);
					check_field("fault_total", m_tdata[37:22], want.total);
				end
			end
			if (s_tvalid && s_tready) begin
				lookup_q.push_back(lru_lookup({s_tuser[0], s_tdata[PAGE_W-1:0]}));
				n_taken++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("lru_page_replacement_core: mismatch");
			$finish;
		end
	end

	initial begin
		frames_clear();
		for (int i = 0; i < 8; i++)
			pool[i] = PAGE_W'($urandom);

		// directed: fills, hits at the oldest, a middle and the youngest age, replacements, clears, stale frames
		push_access(CMD_CLEAR,  20'h00000);
		push_access(CMD_ACCESS, 20'h00000);  // fill frame 0
		push_access(CMD_ACCESS, 20'hFFFFF);  // fill frame 1
		push_access(CMD_ACCESS, 20'h00000);  // hit frame 0, the older of two
		push_access(CMD_ACCESS, 20'h00001);  // fill frame 2
		push_access(CMD_ACCESS, 20'h80000);  // fill frame 3
		push_access(CMD_ACCESS, 20'hFFFFE);  // replace oldest
		push_access(CMD_ACCESS, 20'h80000);  // hit
		push_access(CMD_ACCESS, 20'h00000);  // hit oldest
		push_access(CMD_ACCESS, 20'h00000);  // hit youngest
		push_access(CMD_ACCESS, 20'h55555);  // replace
		push_access(CMD_ACCESS, 20'hAAAAA);  // replace
		push_access(CMD_ACCESS, 20'h00001);  // miss on evicted page
		push_access(CMD_CLEAR,  20'hFFFFF);  // page ignored on clear
		push_access(CMD_ACCESS, 20'hAAAAA);  // stale page in empty frame must miss
		push_access(CMD_ACCESS, 20'h55555);
		push_access(CMD_CLEAR,  20'h12345);
		push_access(CMD_CLEAR,  20'h00000);  // back-to-back clears
		push_access(CMD_ACCESS, 20'hFFFFF);
		push_access(CMD_ACCESS, 20'hFFFFF);
		push_access(CMD_ACCESS, 20'h7FFFF);
		push_access(CMD_ACCESS, 20'hFFFFF);
		add_random(RANDOM_PER_PHASE);

		send_idle = 28;
		recv_idle = 57;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait_drained();

		send_idle = 57;
		recv_idle = 28;
		add_random(RANDOM_PER_PHASE);
		wait_drained();

		// full rate: random traffic, then a clear and a little more traffic
		send_idle = 0;
		recv_idle = 0;
		add_random(RANDOM_PER_PHASE);
		push_access(CMD_CLEAR, 20'h00000);
		add_random(40);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (lookup_q.size() != 0)
			report_mismatch("results never seen", lookup_q.size(), 0);

		$display("covered %0d transactions: %0d hits, %0d fills, %0d replacements, %0d clears",
			n_taken, n_hit, n_fill, n_repl, n_clear);
		$display("fault count saturation reached: %s, errors: %0d",
			saturated ? "yes" : "no", errors);
		if (errors == 0) begin
			$display("lru_page_replacement_core: match");
		end else begin
			$display("lru_page_replacement_core: mismatch");
		end
		$finish;
	end

endmodule

FILE: lru_page_replacement_core.f
design/lrp_pkg.sv
design/lrp_ctrl.sv
design/lrp_datapath.sv
design/lru_page_replacement_core.sv
dv/lru_page_replacement_core_tb.sv
